FILE: design/hpr_pkg.sv
package hpr_pkg;

  // Field widths of the item and result words.
  localparam int POS_W    = 11;
  localparam int TAP_W    = 4;
  localparam int SAMPLE_W = 16;
  localparam int CFG_W    = 5;
  localparam int CFG_IDX_W = 2;

  // Opcodes of an input word; the command queue carries the same codes.
  localparam logic [1:0] OP_PIXEL = 2'd0;
  localparam logic [1:0] OP_START = 2'd1;
  localparam logic [1:0] OP_COEF  = 2'd2;
  localparam logic [1:0] OP_CALC  = 2'd3;

  // Configuration register indexes.
  localparam logic [CFG_IDX_W-1:0] CFG_BITS = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_TAPS = 2'd1;

  // Q1.14 rounding and sample depth limits.
  localparam int Q_SHIFT  = 14;
  localparam int Q_HALF   = 8192;
  localparam int MIN_BITS = 8;
  localparam int MAX_BITS = 16;

  // Classified command passed from the front end to the execution unit.
  typedef struct packed {
    logic [1:0]          kind;
    logic [POS_W-1:0]    pos;
    logic [TAP_W-1:0]    tap;
    logic [SAMPLE_W-1:0] data;
  } cmd_t;

  // Finished output pixel.
  typedef struct packed {
    logic [SAMPLE_W-1:0] pixel;
    logic [POS_W-1:0]    pos;
  } res_t;

endpackage

FILE: design/hpr_fifo.sv
module hpr_fifo #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 4
) (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             push,
  input  logic [WIDTH-1:0] wdata,
  output logic             full,
  input  logic             pop,
  output logic [WIDTH-1:0] rdata,
  output logic             empty
);

  localparam int PW = $clog2(DEPTH);
  localparam int CW = $clog2(DEPTH + 1);

  logic [WIDTH-1:0] mem_r [DEPTH];
  logic [PW-1:0]    wr_ptr_r;
  logic [PW-1:0]    rd_ptr_r;
  logic [CW-1:0]    count_r;
  logic             do_push;
  logic             do_pop;

  assign full    = (count_r == CW'(DEPTH));
  assign empty   = (count_r == '0);
  assign do_push = push && !full;
  assign do_pop  = pop && !empty;
  assign rdata   = mem_r[rd_ptr_r];

  always_ff @(posedge clk) begin
    if (do_push) begin
      mem_r[wr_ptr_r] <= wdata;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      if (do_push) begin
        wr_ptr_r <= (wr_ptr_r == PW'(DEPTH - 1)) ? '0 : wr_ptr_r + 1'b1;
      end
      if (do_pop) begin
        rd_ptr_r <= (rd_ptr_r == PW'(DEPTH - 1)) ? '0 : rd_ptr_r + 1'b1;
      end
      if (do_push && !do_pop) begin
        count_r <= count_r + 1'b1;
      end else if (do_pop && !do_push) begin
        count_r <= count_r - 1'b1;
      end
    end
  end

endmodule

FILE: design/hpr_front.sv
module hpr_front #(
  parameter int SRC_WIDTH_MAX = 2048,
  parameter int DST_WIDTH_MAX = 2048,
  parameter int TAPS          = 16
) (
  input  logic                                push,
  output logic                                full,
  input  logic [1:0]                          opcode,
  input  logic [hpr_pkg::POS_W-1:0]           position,
  input  logic [hpr_pkg::TAP_W-1:0]           tap_number,
  input  logic [hpr_pkg::SAMPLE_W-1:0]        sample_value,
  input  logic signed [hpr_pkg::SAMPLE_W-1:0] weight,
  input  logic                                cmd_full,
  output logic                                cmd_push,
  output hpr_pkg::cmd_t                       cmd
);

  // Largest window start that keeps a full window inside the line store.
  localparam int START_LIM = (SRC_WIDTH_MAX > TAPS) ? (SRC_WIDTH_MAX - TAPS) : 0;

  logic in_range;
  logic src_ok;
  logic dst_ok;

  assign src_ok = (32'(position) < SRC_WIDTH_MAX);
  assign dst_ok = (32'(position) < DST_WIDTH_MAX);

  always_comb begin
    cmd.kind = opcode;
    cmd.pos  = position;
    cmd.tap  = '0;
    cmd.data = sample_value;
    in_range = dst_ok;
    unique case (opcode)
      hpr_pkg::OP_PIXEL: begin
        in_range = src_ok;
      end
      hpr_pkg::OP_START: begin
        if (32'(sample_value) > START_LIM) begin
          cmd.data = hpr_pkg::SAMPLE_W'(START_LIM);
        end
      end
      hpr_pkg::OP_COEF: begin
        in_range = dst_ok && (32'(tap_number) < TAPS);
        cmd.tap  = tap_number;
        cmd.data = weight;
      end
      hpr_pkg::OP_CALC: begin
        in_range = dst_ok;
      end
      default: begin
        in_range = 1'b0;
      end
    endcase
  end

  // Out-of-range words are accepted and dropped here.
  assign full     = cmd_full;
  assign cmd_push = push && !cmd_full && in_range;

endmodule

FILE: design/hpr_back.sv
module hpr_back #(
  parameter int SRC_WIDTH_MAX = 2048,
  parameter int DST_WIDTH_MAX = 2048,
  parameter int TAPS          = 16
) (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          cmd_empty,
  output logic                          cmd_pop,
  input  hpr_pkg::cmd_t                 cmd,
  input  logic [hpr_pkg::CFG_W-1:0]     bits_eff,
  input  logic [$clog2(TAPS + 1)-1:0]   taps_eff,
  input  logic                          res_full,
  output logic                          res_push,
  output hpr_pkg::res_t                 res
);

  localparam int SAW = $clog2(SRC_WIDTH_MAX);
  localparam int DAW = $clog2(DST_WIDTH_MAX);
  localparam int CAW = $clog2(DST_WIDTH_MAX * TAPS);
  localparam int IXW = $clog2(SRC_WIDTH_MAX + TAPS);
  localparam int TCW = $clog2(TAPS + 1);
  localparam int PRW = 2 * hpr_pkg::SAMPLE_W + 1;
  localparam int ACW = PRW + $clog2(TAPS) + 2;
  localparam int QW  = ACW - hpr_pkg::Q_SHIFT;

  localparam logic [1:0] S_IDLE  = 2'd0;
  localparam logic [1:0] S_LOAD  = 2'd1;
  localparam logic [1:0] S_ISSUE = 2'd2;
  localparam logic [1:0] S_DRAIN = 2'd3;

  logic [hpr_pkg::SAMPLE_W-1:0] src_mem   [SRC_WIDTH_MAX];
  logic [SAW-1:0]               start_mem [DST_WIDTH_MAX];
  logic [hpr_pkg::SAMPLE_W-1:0] coef_mem  [DST_WIDTH_MAX * TAPS];

  logic [1:0]                   state_r, state_nxt;
  logic [TCW-1:0]               k_r, k_nxt;
  logic [IXW-1:0]               idx_r;
  logic [CAW-1:0]               coef_addr_r;
  logic [hpr_pkg::POS_W-1:0]    pos_r;
  logic [SAW-1:0]               start_q_r;
  logic [hpr_pkg::SAMPLE_W-1:0] src_q_r;
  logic signed [hpr_pkg::SAMPLE_W-1:0] coef_q_r;
  logic                         s1_v_r, s1_ok_r, s2_v_r;
  logic signed [PRW-1:0]        prod_r;
  logic signed [ACW-1:0]        acc_r;
  logic signed [ACW-1:0]        rnd;
  logic [QW-1:0]                q_wide;
  logic [hpr_pkg::SAMPLE_W:0]   maxv_w;
  logic [CAW-1:0]               cmd_coef_addr;
  logic                         pipe_idle;

  assign cmd_pop       = (state_r == S_IDLE) && !cmd_empty;
  assign cmd_coef_addr = CAW'(cmd.pos) * CAW'(TAPS) + CAW'(cmd.tap);
  assign pipe_idle     = !s1_v_r && !s2_v_r;

  // Line store, window start table and coefficient table.
  always_ff @(posedge clk) begin
    if (cmd_pop && (cmd.kind == hpr_pkg::OP_PIXEL)) begin
      src_mem[SAW'(cmd.pos)] <= cmd.data;
    end
    src_q_r <= src_mem[SAW'(idx_r)];
  end

  always_ff @(posedge clk) begin
    if (cmd_pop && (cmd.kind == hpr_pkg::OP_START)) begin
      start_mem[DAW'(cmd.pos)] <= SAW'(cmd.data);
    end
    start_q_r <= start_mem[DAW'(cmd.pos)];
  end

  always_ff @(posedge clk) begin
    if (cmd_pop && (cmd.kind == hpr_pkg::OP_COEF)) begin
      coef_mem[cmd_coef_addr] <= cmd.data;
    end
    coef_q_r <= coef_mem[coef_addr_r];
  end

  always_comb begin
    state_nxt = state_r;
    k_nxt     = k_r;
    unique case (state_r)
      S_IDLE: begin
        if (cmd_pop && (cmd.kind == hpr_pkg::OP_CALC)) begin
          state_nxt = S_LOAD;
        end
      end
      S_LOAD: begin
        k_nxt     = '0;
        state_nxt = (taps_eff == '0) ? S_DRAIN : S_ISSUE;
      end
      S_ISSUE: begin
        k_nxt = k_r + 1'b1;
        if (k_r == taps_eff - 1'b1) begin
          state_nxt = S_DRAIN;
        end
      end
      S_DRAIN: begin
        if (res_push) begin
          state_nxt = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
      k_r     <= '0;
      s1_v_r  <= 1'b0;
      s2_v_r  <= 1'b0;
    end else begin
      state_r <= state_nxt;
      k_r     <= k_nxt;
      s1_v_r  <= (state_r == S_ISSUE);
      s2_v_r  <= s1_v_r;
    end
  end

  // Address walk, multiply and accumulate, one tap per cycle.
  always_ff @(posedge clk) begin
    if (cmd_pop) begin
      coef_addr_r <= cmd_coef_addr;
      pos_r       <= cmd.pos;
    end else if (state_r == S_ISSUE) begin
      coef_addr_r <= coef_addr_r + 1'b1;
    end
    if (state_r == S_LOAD) begin
      idx_r <= IXW'(start_q_r);
    end else if (state_r == S_ISSUE) begin
      idx_r <= idx_r + 1'b1;
    end
    s1_ok_r <= (32'(idx_r) < SRC_WIDTH_MAX);
    // Both factors stay signed so that negative coefficients sign-extend.
    if (s1_ok_r) begin
      prod_r <= $signed({1'b0, src_q_r}) * coef_q_r;
    end else begin
      prod_r <= '0;
    end
    if (state_r == S_LOAD) begin
      acc_r <= '0;
    end else if (s2_v_r) begin
      acc_r <= acc_r + ACW'(prod_r);
    end
  end

  // Round half up at the Q1.14 point and clamp to the sample range.
  assign rnd    = acc_r + ACW'(hpr_pkg::Q_HALF);
  assign q_wide = rnd[ACW-1:hpr_pkg::Q_SHIFT];
  assign maxv_w = ((hpr_pkg::SAMPLE_W + 1)'(1) << bits_eff) - 1'b1;

  always_comb begin
    res.pos = pos_r;
    if (rnd[ACW-1]) begin
      res.pixel = '0;
    end else if (q_wide > QW'(maxv_w[hpr_pkg::SAMPLE_W-1:0])) begin
      res.pixel = maxv_w[hpr_pkg::SAMPLE_W-1:0];
    end else begin
      res.pixel = q_wide[hpr_pkg::SAMPLE_W-1:0];
    end
  end

  assign res_push = (state_r == S_DRAIN) && pipe_idle && !res_full;

endmodule

FILE: design/horizontal_polyphase_resampler.sv
// Horizontal polyphase resampler for one image row.
// The input channel is a queue write port: a word is taken at a clock edge with
// push high and full low. Its opcode loads a source pixel, loads the window start
// of an output pixel, loads one Q1.14 coefficient of an output pixel, or asks for
// an output pixel. Only a request gives a word on the result channel, which reads
// like a queue: while empty is low the oldest pixel is on out_pixel_out and
// out_position, and pop takes it.
// Configuration (sample depth at index 0, tap count at index 1) is written through
// cfg_valid and cfg_ready; cfg_ready is always high. The user must write it only
// while the block is idle; the block itself does not enforce this. Words pass a
// four-entry command queue into the execution unit. Loads stream at one per
// cycle while no request is in progress. A request runs through a window start
// read, then one source pixel and one coefficient read per tap, a multiply stage
// and an accumulate stage.
// Finished pixels wait in a two-entry result queue. When the receiver does not
// pop, that queue fills, the execution unit holds its pixel, the command queue
// fills and full rises. Reset empties both queues and sets both configuration
// registers to sixteen; the memories keep their contents and are undefined until
// loaded.
module horizontal_polyphase_resampler #(
  parameter int SRC_WIDTH_MAX = 2048,
  parameter int DST_WIDTH_MAX = 2048,
  parameter int TAPS          = 16
) (
  input  logic                                clk,
  input  logic                                rst_n,
  input  logic                                push,
  output logic                                full,
  input  logic [1:0]                          in_opcode,
  input  logic [hpr_pkg::POS_W-1:0]           in_position,
  input  logic [hpr_pkg::TAP_W-1:0]           in_tap_number,
  input  logic [hpr_pkg::SAMPLE_W-1:0]        in_sample_value,
  input  logic signed [hpr_pkg::SAMPLE_W-1:0] in_weight,
  output logic                                empty,
  input  logic                                pop,
  output logic [hpr_pkg::SAMPLE_W-1:0]        out_pixel_out,
  output logic [hpr_pkg::POS_W-1:0]           out_position,
  input  logic                                cfg_valid,
  output logic                                cfg_ready,
  input  logic [hpr_pkg::CFG_IDX_W-1:0]       cfg_index,
  input  logic [hpr_pkg::CFG_W-1:0]           cfg_data
);

  localparam int TCW = $clog2(TAPS + 1);

  logic [hpr_pkg::CFG_W-1:0] bits_r;
  logic [hpr_pkg::CFG_W-1:0] taps_r;
  logic [hpr_pkg::CFG_W-1:0] bits_eff;
  logic [TCW-1:0]            taps_eff;

  hpr_pkg::cmd_t cmd_in, cmd_out;
  hpr_pkg::res_t res_in, res_out;
  logic          cmd_push, cmd_full, cmd_pop, cmd_empty;
  logic          res_push, res_full;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      bits_r <= hpr_pkg::CFG_W'(hpr_pkg::MAX_BITS);
      taps_r <= hpr_pkg::CFG_W'(16);
    end else if (cfg_valid && cfg_ready) begin
      unique case (cfg_index)
        hpr_pkg::CFG_BITS: bits_r <= cfg_data;
        hpr_pkg::CFG_TAPS: taps_r <= cfg_data;
        default: begin
        end
      endcase
    end
  end

  // Depth outside 8..16 acts as the nearest limit; tap counts above TAPS act as TAPS.
  always_comb begin
    if (32'(bits_r) < hpr_pkg::MIN_BITS) begin
      bits_eff = hpr_pkg::CFG_W'(hpr_pkg::MIN_BITS);
    end else if (32'(bits_r) > hpr_pkg::MAX_BITS) begin
      bits_eff = hpr_pkg::CFG_W'(hpr_pkg::MAX_BITS);
    end else begin
      bits_eff = bits_r;
    end
    if (32'(taps_r) > TAPS) begin
      taps_eff = TCW'(TAPS);
    end else begin
      taps_eff = TCW'(taps_r);
    end
  end

  hpr_front #(
    .SRC_WIDTH_MAX (SRC_WIDTH_MAX),
    .DST_WIDTH_MAX (DST_WIDTH_MAX),
    .TAPS          (TAPS)
  ) u_front (
    .push         (push),
    .full         (full),
    .opcode       (in_opcode),
    .position     (in_position),
    .tap_number   (in_tap_number),
    .sample_value (in_sample_value),
    .weight       (in_weight),
    .cmd_full     (cmd_full),
    .cmd_push     (cmd_push),
    .cmd          (cmd_in)
  );

  hpr_fifo #(
    .WIDTH ($bits(hpr_pkg::cmd_t)),
    .DEPTH (4)
  ) u_cmd_fifo (
    .clk   (clk),
    .rst_n (rst_n),
    .push  (cmd_push),
    .wdata (cmd_in),
    .full  (cmd_full),
    .pop   (cmd_pop),
    .rdata (cmd_out),
    .empty (cmd_empty)
  );

  hpr_back #(
    .SRC_WIDTH_MAX (SRC_WIDTH_MAX),
    .DST_WIDTH_MAX (DST_WIDTH_MAX),
    .TAPS          (TAPS)
  ) u_back (
    .clk       (clk),
    .rst_n     (rst_n),
    .cmd_empty (cmd_empty),
    .cmd_pop   (cmd_pop),
    .cmd       (cmd_out),
    .bits_eff  (bits_eff),
    .taps_eff  (taps_eff),
    .res_full  (res_full),
    .res_push  (res_push),
    .res       (res_in)
  );

  hpr_fifo #(
    .WIDTH ($bits(hpr_pkg::res_t)),
    .DEPTH (2)
  ) u_res_fifo (
    .clk   (clk),
    .rst_n (rst_n),
    .push  (res_push),
    .wdata (res_in),
    .full  (res_full),
    .pop   (pop),
    .rdata (res_out),
    .empty (empty)
  );

  assign out_pixel_out = res_out.pixel;
  assign out_position  = res_out.pos;

endmodule
